// ----- rtl/asl3_pkg.sv -----
package asl3_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int COURANT_W      = 16;
   localparam int GRID_W         = 11;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int ACC_W          = 40;
   localparam int PROD_W         = ACC_W + COURANT_W + 1;
   localparam int MIN_POINTS     = 5;
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DIV_DIGITS     = ACC_W / 8;
   localparam int DIV_CNT_W      = $clog2(DIV_DIGITS);

   localparam logic [CSR_ADDR_W-1:0] CSR_COURANT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VEL_POS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID    = 2'd2;

   localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [7:0] quot;
      logic [1:0] rem;
   } div3_type;

   // One radix-256 digit of a long division by three: (rem*256 + digit) / 3.
   // 683/2048 is close enough to 1/3 to be exact for values below 768.
   function automatic div3_type div3_step(input logic [1:0] rem_in,
                                          input logic [7:0] digit_in);
      logic [9:0]  v;
      logic [19:0] prod;
      logic [9:0]  r10;
      div3_type    res;
      v        = {rem_in, digit_in};
      prod     = {10'd0, v} * 20'd683;
      res.quot = prod[18:11];
      r10      = v - {1'b0, res.quot, 1'b0} - {2'b00, res.quot};
      res.rem  = r10[1:0];
      return res;
   endfunction

   function automatic acc_type sext_sample(input logic [SAMPLE_W-1:0] x);
      return acc_type'({{(ACC_W-SAMPLE_W){x[SAMPLE_W-1]}}, x});
   endfunction

   function automatic logic [SAMPLE_W-1:0] sat_sample(input acc_type x);
      logic [ACC_W-SAMPLE_W:0] top;
      logic [SAMPLE_W-1:0]     res;
      top = x[ACC_W-1:SAMPLE_W-1];
      if (top == '0 || top == '1) begin
         res = x[SAMPLE_W-1:0];
      end else if (x[ACC_W-1]) begin
         res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ----- rtl/advection_semi_lagrange_3rd_top.sv -----
// channel   | ports                                | payload
// ----------+--------------------------------------+----------------------------------
// request   | req_tvalid, req_tready, req_tdata    | sample_value [31:0]
// result    | rsp_tvalid, rsp_tready, rsp_tdata,   | updated_value [31:0],
//           | rsp_tlast                            | tlast = line_end
// config    | csr_we, csr_addr, csr_wdata          | 0 courant, 1 velocity sign, 2 points
//
// An interior point passes through an accept step, a stencil setup step, 5 divide-by-three
// digit steps, a sign fix, 3 multiply/add pairs on the one multiplier and an output load.
// The first two requests of a line give no result, the next two emit the first two samples
// unchanged; the request that ends a line also emits the last two samples as its tail.
// Reset is synchronous; it clears the window and the point index and resets the control registers.
// req_tready is high only between requests; a stalled result holds in the output
// register and the next request is taken once the last result is loaded.
module advection_semi_lagrange_3rd_top
   import asl3_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [31:0] sample_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // [31:0] updated_value
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int NW    = (IDX_W + 1 > GRID_W) ? IDX_W + 1 : GRID_W;
   localparam int HW    = 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PREP   = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_SIGN   = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_ADD    = 4'd5;
   localparam logic [3:0] S_EMIT_C = 4'd6;
   localparam logic [3:0] S_EMIT_M = 4'd7;
   localparam logic [3:0] S_EMIT_L = 4'd8;

   localparam logic [HW-1:0] H_C2 = 2'd0;
   localparam logic [HW-1:0] H_C1 = 2'd1;
   localparam logic [HW-1:0] H_C0 = 2'd2;

   // control
   logic [3:0]           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COURANT_W-1:0] courant_ff, courant_in;
   logic                 vel_ff, vel_in;
   logic [GRID_W-1:0]    grid_ff, grid_in;
   logic [SAMPLE_W-1:0]  win_ff [5];
   logic [SAMPLE_W-1:0]  win_in [5];

   // datapath
   logic                 calc_ff, calc_in;
   logic                 last_ff, last_in;
   logic [ACC_W-1:0]     dvd1_ff, dvd1_in, dvd3_ff, dvd3_in;
   logic [ACC_W-1:0]     quo1_ff, quo1_in, quo3_ff, quo3_in;
   logic [1:0]           rem1_ff, rem1_in, rem3_ff, rem3_in;
   logic                 neg1_ff, neg1_in, neg3_ff, neg3_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [HW-1:0]        horner_ff, horner_in;
   acc_type              c1_ff, c1_in, c2_ff, c2_in, t_ff, t_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SAMPLE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_acc, out_free;
   logic [NW-1:0]        n_eff, p_next;
   acc_type              a_s, b_s, c_s, d_s, num1, num3, mag1, mag3, addend;
   div3_type             st1, st3;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      if (NW'(grid_ff) < NW'(MIN_POINTS)) begin
         n_eff = NW'(MIN_POINTS);
      end else if (NW'(grid_ff) > NW'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(grid_ff);
      end
      p_next = NW'(idx_ff) + NW'(1);
   end

   // stencil, mirrored by velocity sign; win[0] is the newest sample
   always_comb begin
      a_s  = sext_sample(vel_ff ? win_ff[4] : win_ff[0]);
      b_s  = sext_sample(vel_ff ? win_ff[3] : win_ff[1]);
      c_s  = sext_sample(win_ff[2]);
      d_s  = sext_sample(vel_ff ? win_ff[1] : win_ff[3]);
      num1 = -a_s + (b_s <<< 2) + (b_s <<< 1) - (c_s <<< 1) - c_s - (d_s <<< 1);
      num3 = a_s - (b_s <<< 1) - b_s + (c_s <<< 1) + c_s - d_s;
      mag1 = num1[ACC_W-1] ? -num1 : num1;
      mag3 = num3[ACC_W-1] ? -num3 : num3;
      st1  = div3_step(rem1_ff, dvd1_ff[ACC_W-1:ACC_W-8]);
      st3  = div3_step(rem3_ff, dvd3_ff[ACC_W-1:ACC_W-8]);
      case (horner_ff)
         H_C2:    addend = c2_ff;
         H_C1:    addend = c1_ff;
         default: addend = c_s;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      courant_in   = courant_ff;
      vel_in       = vel_ff;
      grid_in      = grid_ff;
      win_in       = win_ff;
      calc_in      = calc_ff;
      last_in      = last_ff;
      dvd1_in      = dvd1_ff;
      dvd3_in      = dvd3_ff;
      quo1_in      = quo1_ff;
      quo3_in      = quo3_ff;
      rem1_in      = rem1_ff;
      rem3_in      = rem3_ff;
      neg1_in      = neg1_ff;
      neg3_in      = neg3_ff;
      dcnt_in      = dcnt_ff;
      horner_in    = horner_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_COURANT: courant_in = csr_wdata[COURANT_W-1:0];
            CSR_VEL_POS: vel_in     = csr_wdata[0];
            CSR_GRID:    grid_in    = csr_wdata[GRID_W-1:0];
            default:     ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               win_in[0] = req_tdata;
               for (int k = 1; k < 5; k++) begin
                  win_in[k] = win_ff[k-1];
               end
               last_in = (p_next >= n_eff);
               calc_in = (idx_ff >= IDX_W'(4));
               idx_in  = (p_next >= n_eff) ? '0 : p_next[IDX_W-1:0];
               if (idx_ff >= IDX_W'(4)) begin
                  state_in = S_PREP;
               end else if (idx_ff >= IDX_W'(2)) begin
                  state_in = S_EMIT_C;
               end
            end
         end
         S_PREP: begin
            c2_in    = (b_s - (c_s <<< 1) + d_s) >>> 1;
            // |x|/6 = floor(floor(|x|/2) / 3)
            dvd1_in  = mag1 >> 1;
            dvd3_in  = mag3 >> 1;
            neg1_in  = num1[ACC_W-1];
            neg3_in  = num3[ACC_W-1];
            rem1_in  = '0;
            rem3_in  = '0;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            quo1_in = {quo1_ff[ACC_W-9:0], st1.quot};
            quo3_in = {quo3_ff[ACC_W-9:0], st3.quot};
            rem1_in = st1.rem;
            rem3_in = st3.rem;
            dvd1_in = dvd1_ff << 8;
            dvd3_in = dvd3_ff << 8;
            dcnt_in = dcnt_ff + DIV_CNT_W'(1);
            if (dcnt_ff == DIV_CNT_W'(DIV_DIGITS - 1)) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            c1_in     = neg1_ff ? -acc_type'(quo1_ff) : acc_type'(quo1_ff);
            t_in      = neg3_ff ? -acc_type'(quo3_ff) : acc_type'(quo3_ff);
            horner_in = H_C2;
            state_in  = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(t_ff) * PROD_W'($signed({1'b0, courant_ff}));
            state_in = S_ADD;
         end
         S_ADD: begin
            t_in      = addend + acc_type'(prod_ff[ACC_W+COURANT_W-1:COURANT_W]);
            horner_in = horner_ff + HW'(1);
            state_in  = (horner_ff == H_C0) ? S_EMIT_C : S_MUL;
         end
         S_EMIT_C: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = calc_ff ? sat_sample(t_ff) : win_ff[2];
               rsp_last_in  = 1'b0;
               state_in     = last_ff ? S_EMIT_M : S_IDLE;
            end
         end
         S_EMIT_M: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = win_ff[1];
               rsp_last_in  = 1'b0;
               state_in     = S_EMIT_L;
            end
         end
         S_EMIT_L: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = win_ff[0];
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         courant_ff   <= '0;
         vel_ff       <= 1'b1;
         grid_ff      <= GRID_RESET;
         for (int k = 0; k < 5; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         courant_ff   <= courant_in;
         vel_ff       <= vel_in;
         grid_ff      <= grid_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      calc_ff     <= calc_in;
      last_ff     <= last_in;
      dvd1_ff     <= dvd1_in;
      dvd3_ff     <= dvd3_in;
      quo1_ff     <= quo1_in;
      quo3_ff     <= quo3_in;
      rem1_ff     <= rem1_in;
      rem3_ff     <= rem3_in;
      neg1_ff     <= neg1_in;
      neg3_ff     <= neg3_in;
      dcnt_ff     <= dcnt_in;
      horner_ff   <= horner_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < IDX_W'(MAX_POINTS - 1) || idx_ff == IDX_W'(MAX_POINTS - 1))
      else $error("point index out of range");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_SIGN) |-> (rem1_ff != 2'd3 && rem3_ff != 2'd3))
      else $error("divide remainder out of range");

   a_horner_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_ADD) |-> horner_ff != 2'd3)
      else $error("horner step out of range");

   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT_C || $past(state_ff) == S_EMIT_M
                               || $past(state_ff) == S_EMIT_L))
      else $error("result appeared outside an emit step");

endmodule
